// ===== rtl/bpc_pkg.sv =====
// Shared types, constants and fixed-point helpers of the barometric compensation unit.
package bpc_pkg;

  // Resolution of the raw converter readings; readings are MSB-aligned at 20 bits.
  localparam int unsigned RAW_BITS = 20;
  localparam logic [19:0] RAW_MASK = ~((20'd1 << (20 - RAW_BITS)) - 20'd1);

  // Configuration register indexes.
  localparam logic [1:0] CFG_CALIB_TEMP      = 2'd0;
  localparam logic [1:0] CFG_CALIB_PRES_LOW  = 2'd1;
  localparam logic [1:0] CFG_CALIB_PRES_HIGH = 2'd2;
  localparam logic [1:0] CFG_CALIB_PRES_LAST = 2'd3;

  // Number of restoring steps in the pressure divider, one quotient bit each.
  localparam int unsigned DIV_STEPS = 64;

  // Cycles from the accepting edge to the edge at which the receiver takes the result.
  localparam int unsigned BPC_LATENCY = 12 + DIV_STEPS + 8;

  // Temperature results and the divide-by-zero flag that ride along with the pressure computation.
  typedef struct packed {
    logic [31:0] tfine;
    logic [31:0] tcent;
    logic        dz;
  } bpc_side_t;

  // Signed divide by 2**k that truncates toward zero (bias negatives, then shift).
  function automatic logic [31:0] sdiv_p2_32(input logic [31:0] x, input int unsigned k);
    logic [31:0] bias;
    logic [31:0] sum;
    bias = x[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
    sum  = x + bias;
    return 32'($signed(sum) >>> k);
  endfunction

  function automatic logic [63:0] sdiv_p2_64(input logic [63:0] x, input int unsigned k);
    logic [63:0] bias;
    logic [63:0] sum;
    bias = x[63] ? ((64'd1 << k) - 64'd1) : 64'd0;
    sum  = x + bias;
    return 64'($signed(sum) >>> k);
  endfunction

endpackage

// ===== rtl/bpc_div.sv =====
// Fully pipelined 64-bit unsigned restoring divider, one quotient bit per stage.
module bpc_div
  import bpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  input  bpc_side_t   side_i,
  output logic        valid_o,
  output logic [63:0] quo_o,
  output bpc_side_t   side_o
);

  logic [63:0] rem_q  [DIV_STEPS];
  logic [63:0] num_q  [DIV_STEPS];
  logic [63:0] den_q  [DIV_STEPS];
  bpc_side_t   side_q [DIV_STEPS];
  logic [DIV_STEPS-1:0] vld_q;

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
    logic [63:0] rem_in;
    logic [63:0] num_in;
    logic [63:0] den_in;
    bpc_side_t   side_in;
    logic        vld_in;
    logic [64:0] trial;

    if (g == 0) begin : g_first
      assign rem_in  = 64'd0;
      assign num_in  = num_i;
      assign den_in  = den_i;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign num_in  = num_q[g-1];
      assign den_in  = den_q[g-1];
      assign side_in = side_q[g-1];
      assign vld_in  = vld_q[g-1];
    end

    // The partial remainder stays below the divisor, which is at most 2**63.
    assign trial = {1'b0, rem_in[62:0], num_in[63]} - {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (trial[64]) begin
        rem_q[g] <= {rem_in[62:0], num_in[63]};
      end else begin
        rem_q[g] <= trial[63:0];
      end
      num_q[g]  <= {num_in[62:0], ~trial[64]};
      den_q[g]  <= den_in;
      side_q[g] <= side_in;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= vld_in;
      end
    end
  end

  assign valid_o = vld_q[DIV_STEPS-1];
  assign quo_o   = num_q[DIV_STEPS-1];
  assign side_o  = side_q[DIV_STEPS-1];

endmodule

// ===== rtl/baro_temp_pressure_compensation_unit.sv =====
// Top level of the barometric temperature and pressure compensation unit.
//
// The unit takes one transaction (a raw pressure and a raw temperature reading) at
// every rising edge where start is high and busy is low; busy is never raised, so a
// new transaction may enter in every clock cycle. Each transaction yields exactly one
// result, shown on the result ports for one cycle with valid_o high; results leave in
// the order of acceptance. The receiver cannot stall the unit. The pipeline consists of
// a 12-stage front end for the temperature formula and the pressure numerator and
// denominator, a 64-stage restoring divider that produces one quotient bit per stage,
// and an 8-stage back end for the final pressure corrections. Every stage holds a few
// multipliers of at most 32 by 32 bits (or 33 by 16 bits) or a short chain of 64-bit
// adds. The calibration words are written through the cfg port, must only change while
// no transaction is in flight, and reset to zero.
module baro_temp_pressure_compensation_unit
  import bpc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [19:0]        raw_pressure_i,
  input  logic [19:0]        raw_temperature_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [63:0]        cfg_wdata_i,
  output logic               valid_o,
  output logic signed [31:0] fine_temperature_o,
  output logic signed [31:0] temperature_centi_o,
  output logic [31:0]        pressure_q24_8_o,
  output logic               divide_by_zero_o
);

  // Calibration registers.
  logic [47:0] calib_temp_q;
  logic [63:0] calib_pres_low_q;
  logic [63:0] calib_pres_high_q;
  logic [15:0] calib_pres_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_temp_q      <= '0;
      calib_pres_low_q  <= '0;
      calib_pres_high_q <= '0;
      calib_pres_last_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CALIB_TEMP:      calib_temp_q      <= cfg_wdata_i[47:0];
        CFG_CALIB_PRES_LOW:  calib_pres_low_q  <= cfg_wdata_i;
        CFG_CALIB_PRES_HIGH: calib_pres_high_q <= cfg_wdata_i;
        CFG_CALIB_PRES_LAST: calib_pres_last_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = calib_temp_q[15:0];
  assign t2 = calib_temp_q[31:16];
  assign t3 = calib_temp_q[47:32];
  assign p1 = calib_pres_low_q[15:0];
  assign p2 = calib_pres_low_q[31:16];
  assign p3 = calib_pres_low_q[47:32];
  assign p4 = calib_pres_low_q[63:48];
  assign p5 = calib_pres_high_q[15:0];
  assign p6 = calib_pres_high_q[31:16];
  assign p7 = calib_pres_high_q[47:32];
  assign p8 = calib_pres_high_q[63:48];
  assign p9 = calib_pres_last_q;

  // The pipeline has no stall, so the unit is always ready.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // Front-end valid bits, one per stage S0..S11.
  logic [11:0] pre_v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_v_q <= '0;
    end else begin
      pre_v_q <= {pre_v_q[10:0], accept};
    end
  end

  // S0: capture aligned readings.
  logic [19:0] s0_adcp_q, s0_adct_q;
  // S1: temperature products.
  logic [31:0] s1_m1_q, s1_dd_q;
  logic [19:0] s1_adcp_q;
  // S2.
  logic [31:0] s2_a_q, s2_m2_q;
  logic [19:0] s2_adcp_q;
  // S3.
  logic [31:0] s3_tf_q;
  logic [19:0] s3_adcp_q;
  // S4.
  logic [31:0] s4_tf_q, s4_tc_q, s4_u_q;
  logic [32:0] s4_v1_q;
  logic [19:0] s4_adcp_q;
  // S5.
  logic [31:0] s5_tf_q, s5_tcent_q;
  logic [63:0] s5_vv_q;
  logic signed [48:0] s5_pp5_q, s5_pp2_q;
  logic [19:0] s5_adcp_q;
  // S6.
  logic [31:0] s6_tf_q, s6_tcent_q;
  logic signed [48:0] s6_lo6_q, s6_lo3_q, s6_pp5_q, s6_pp2_q;
  logic [31:0] s6_hi6_q, s6_hi3_q;
  logic [19:0] s6_adcp_q;
  // S7.
  logic [31:0] s7_tf_q, s7_tcent_q;
  logic [63:0] s7_v2_q, s7_vv3_q;
  logic signed [48:0] s7_pp2_q;
  logic [19:0] s7_adcp_q;
  // S8.
  logic [31:0] s8_tf_q, s8_tcent_q;
  logic [63:0] s8_v1a_q, s8_n0_q;
  // S9.
  logic [31:0] s9_tf_q, s9_tcent_q;
  logic [47:0] s9_lo1_q;
  logic [43:0] s9_lon_q;
  logic [31:0] s9_hi1_q, s9_hin_q;
  // S10.
  logic [31:0] s10_tf_q, s10_tcent_q;
  logic [63:0] s10_denr_q, s10_num_q;
  // S11.
  logic [31:0] s11_tf_q, s11_tcent_q;
  logic [63:0] s11_den_q, s11_num_q;

  // Combinational values of the front end.
  logic [31:0] s1_x, s1_d, s1_m1_d, s1_dd_d;
  logic [31:0] s2_a_d, s2_m2_d;
  logic [32:0] s4_v1_d;
  logic [31:0] s4_u_d;
  logic signed [48:0] s5_pp5_d, s5_pp2_d, s6_lo6_d, s6_lo3_d;
  logic [31:0] s6_hi6_d, s6_hi3_d;
  logic [63:0] s7_vv6, s7_v2_d, s7_vv3_d;
  logic [20:0] s8_pr0;
  logic [63:0] s8_v1a_d, s8_n0_d;

  assign s1_x    = 32'(s0_adct_q >> 3) - 32'({t1, 1'b0});
  assign s1_d    = 32'(s0_adct_q >> 4) - 32'(t1);
  assign s1_m1_d = s1_x * {{16{t2[15]}}, t2};
  assign s1_dd_d = s1_d * s1_d;

  assign s2_a_d  = sdiv_p2_32(s1_m1_q, 11);
  assign s2_m2_d = sdiv_p2_32(s1_dd_q, 12) * {{16{t3[15]}}, t3};

  assign s4_v1_d = {s3_tf_q[31], s3_tf_q} - 33'd128000;
  assign s4_u_d  = s4_v1_d[32] ? 32'(-s4_v1_d) : s4_v1_d[31:0];

  assign s5_pp5_d = $signed(s4_v1_q) * $signed(p5);
  assign s5_pp2_d = $signed(s4_v1_q) * $signed(p2);

  assign s6_lo6_d = $signed({1'b0, s5_vv_q[31:0]}) * $signed(p6);
  assign s6_hi6_d = s5_vv_q[63:32] * {{16{p6[15]}}, p6};
  assign s6_lo3_d = $signed({1'b0, s5_vv_q[31:0]}) * $signed(p3);
  assign s6_hi3_d = s5_vv_q[63:32] * {{16{p3[15]}}, p3};

  assign s7_vv6   = {s6_hi6_q, 32'd0} + {{15{s6_lo6_q[48]}}, s6_lo6_q};
  assign s7_v2_d  = s7_vv6 + ({{15{s6_pp5_q[48]}}, s6_pp5_q} << 17)
                  + ({{48{p4[15]}}, p4} << 35);
  assign s7_vv3_d = {s6_hi3_q, 32'd0} + {{15{s6_lo3_q[48]}}, s6_lo3_q};

  assign s8_pr0   = 21'd1048576 - {1'b0, s7_adcp_q};
  assign s8_n0_d  = (64'(s8_pr0) << 31) - s7_v2_q;
  assign s8_v1a_d = sdiv_p2_64(s7_vv3_q, 8) + ({{15{s7_pp2_q[48]}}, s7_pp2_q} << 12)
                  + 64'h0000_8000_0000_0000;

  always_ff @(posedge clk_i) begin
    s0_adcp_q   <= raw_pressure_i & RAW_MASK;
    s0_adct_q   <= raw_temperature_i & RAW_MASK;

    s1_m1_q     <= s1_m1_d;
    s1_dd_q     <= s1_dd_d;
    s1_adcp_q   <= s0_adcp_q;

    s2_a_q      <= s2_a_d;
    s2_m2_q     <= s2_m2_d;
    s2_adcp_q   <= s1_adcp_q;

    s3_tf_q     <= s2_a_q + sdiv_p2_32(s2_m2_q, 14);
    s3_adcp_q   <= s2_adcp_q;

    s4_tf_q     <= s3_tf_q;
    s4_tc_q     <= s3_tf_q * 32'd5 + 32'd128;
    s4_v1_q     <= s4_v1_d;
    s4_u_q      <= s4_u_d;
    s4_adcp_q   <= s3_adcp_q;

    s5_tf_q     <= s4_tf_q;
    s5_tcent_q  <= sdiv_p2_32(s4_tc_q, 8);
    s5_vv_q     <= s4_u_q * s4_u_q;
    s5_pp5_q    <= s5_pp5_d;
    s5_pp2_q    <= s5_pp2_d;
    s5_adcp_q   <= s4_adcp_q;

    s6_tf_q     <= s5_tf_q;
    s6_tcent_q  <= s5_tcent_q;
    s6_lo6_q    <= s6_lo6_d;
    s6_hi6_q    <= s6_hi6_d;
    s6_lo3_q    <= s6_lo3_d;
    s6_hi3_q    <= s6_hi3_d;
    s6_pp5_q    <= s5_pp5_q;
    s6_pp2_q    <= s5_pp2_q;
    s6_adcp_q   <= s5_adcp_q;

    s7_tf_q     <= s6_tf_q;
    s7_tcent_q  <= s6_tcent_q;
    s7_v2_q     <= s7_v2_d;
    s7_vv3_q    <= s7_vv3_d;
    s7_pp2_q    <= s6_pp2_q;
    s7_adcp_q   <= s6_adcp_q;

    s8_tf_q     <= s7_tf_q;
    s8_tcent_q  <= s7_tcent_q;
    s8_v1a_q    <= s8_v1a_d;
    s8_n0_q     <= s8_n0_d;

    // Products by the unsigned word P1 and by 3125, split into 32-bit halves.
    s9_tf_q     <= s8_tf_q;
    s9_tcent_q  <= s8_tcent_q;
    s9_lo1_q    <= s8_v1a_q[31:0] * p1;
    s9_hi1_q    <= s8_v1a_q[63:32] * {16'd0, p1};
    s9_lon_q    <= s8_n0_q[31:0] * 12'd3125;
    s9_hin_q    <= s8_n0_q[63:32] * 32'd3125;

    s10_tf_q    <= s9_tf_q;
    s10_tcent_q <= s9_tcent_q;
    s10_denr_q  <= {s9_hi1_q, 32'd0} + 64'(s9_lo1_q);
    s10_num_q   <= {s9_hin_q, 32'd0} + 64'(s9_lon_q);

    s11_tf_q    <= s10_tf_q;
    s11_tcent_q <= s10_tcent_q;
    s11_den_q   <= sdiv_p2_64(s10_denr_q, 33);
    s11_num_q   <= s10_num_q;
  end

  // The divider works on magnitudes; the quotient sign is restored afterwards.
  bpc_side_t   div_side_in, div_side_out;
  logic [63:0] div_num_mag, div_den_mag, div_quo;
  logic        div_vld_out;
  logic        s12_neg;

  assign div_num_mag = s11_num_q[63] ? -s11_num_q : s11_num_q;
  assign div_den_mag = s11_den_q[63] ? -s11_den_q : s11_den_q;
  assign s12_neg     = s11_num_q[63] ^ s11_den_q[63];
  assign div_side_in = '{tfine: s11_tf_q, tcent: s11_tcent_q, dz: (s11_den_q == 64'd0)};

  // The sign travels in a small shift line next to the divider.
  logic [DIV_STEPS-1:0] neg_q;
  always_ff @(posedge clk_i) begin
    neg_q <= {neg_q[DIV_STEPS-2:0], s12_neg};
  end

  bpc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pre_v_q[11]),
    .num_i   (div_num_mag),
    .den_i   (div_den_mag),
    .side_i  (div_side_in),
    .valid_o (div_vld_out),
    .quo_o   (div_quo),
    .side_o  (div_side_out)
  );

  // Back end: stages Q0..Q7, the last one drives the result ports.
  logic [7:0] post_v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      post_v_q <= '0;
    end else begin
      post_v_q <= {post_v_q[6:0], div_vld_out};
    end
  end

  bpc_side_t q0_side_q, q1_side_q, q2_side_q, q3_side_q, q4_side_q, q5_side_q, q6_side_q;
  logic [63:0] q0_q_q, q1_q_q, q1_a_q, q2_q_q, q2_pp8_q, q3_q_q, q3_sql_q, q3_v2b_q;
  logic [63:0] q4_q_q, q4_sq_q, q4_v2b_q, q5_q_q, q5_v2b_q, q6_q_q, q6_s9_q, q6_v2b_q;
  logic [50:0] q2_ua_q;
  logic [31:0] q1_hi8_q, q3_sqx_q, q5_hi9_q;
  logic signed [48:0] q1_lo8_q, q5_lo9_q;

  logic [63:0] q1_a_d, q2_pp8_d, q4_sq_d, q6_s9_d, q7_sum, q7_res;
  logic signed [48:0] q1_lo8_d, q5_lo9_d;
  logic [63:0] q2_amag;

  assign q1_a_d   = sdiv_p2_64(q0_q_q, 13);
  assign q1_lo8_d = $signed({1'b0, q0_q_q[31:0]}) * $signed(p8);
  assign q2_pp8_d = {q1_hi8_q, 32'd0} + {{15{q1_lo8_q[48]}}, q1_lo8_q};
  assign q2_amag  = q1_a_q[63] ? -q1_a_q : q1_a_q;
  // The square of a signed value is the square of its magnitude; only 64 bits are kept.
  assign q4_sq_d  = q3_sql_q + {q3_sqx_q[30:0], 33'd0};
  assign q5_lo9_d = $signed({1'b0, q4_sq_q[31:0]}) * $signed(p9);
  assign q6_s9_d  = {q5_hi9_q, 32'd0} + {{15{q5_lo9_q[48]}}, q5_lo9_q};
  assign q7_sum   = q6_q_q + sdiv_p2_64(q6_s9_q, 25) + q6_v2b_q;
  assign q7_res   = sdiv_p2_64(q7_sum, 8) + ({{48{p7[15]}}, p7} << 4);

  always_ff @(posedge clk_i) begin
    q0_side_q <= div_side_out;
    q0_q_q    <= neg_q[DIV_STEPS-1] ? -div_quo : div_quo;

    q1_side_q <= q0_side_q;
    q1_q_q    <= q0_q_q;
    q1_a_q    <= q1_a_d;
    q1_lo8_q  <= q1_lo8_d;
    q1_hi8_q  <= q0_q_q[63:32] * {{16{p8[15]}}, p8};

    q2_side_q <= q1_side_q;
    q2_q_q    <= q1_q_q;
    q2_ua_q   <= q2_amag[50:0];
    q2_pp8_q  <= q2_pp8_d;

    q3_side_q <= q2_side_q;
    q3_q_q    <= q2_q_q;
    q3_sql_q  <= q2_ua_q[31:0] * q2_ua_q[31:0];
    q3_sqx_q  <= 32'(q2_ua_q[50:32]) * q2_ua_q[31:0];
    q3_v2b_q  <= sdiv_p2_64(q2_pp8_q, 19);

    q4_side_q <= q3_side_q;
    q4_q_q    <= q3_q_q;
    q4_sq_q   <= q4_sq_d;
    q4_v2b_q  <= q3_v2b_q;

    q5_side_q <= q4_side_q;
    q5_q_q    <= q4_q_q;
    q5_lo9_q  <= q5_lo9_d;
    q5_hi9_q  <= q4_sq_q[63:32] * {{16{p9[15]}}, p9};
    q5_v2b_q  <= q4_v2b_q;

    q6_side_q <= q5_side_q;
    q6_q_q    <= q5_q_q;
    q6_s9_q   <= q6_s9_d;
    q6_v2b_q  <= q5_v2b_q;

    fine_temperature_o  <= q6_side_q.tfine;
    temperature_centi_o <= q6_side_q.tcent;
    divide_by_zero_o    <= q6_side_q.dz;
    pressure_q24_8_o    <= q6_side_q.dz ? 32'd0 : q7_res[31:0];
  end

  assign valid_o = post_v_q[7];

endmodule

// ===== rtl/bpc_checker.sv =====
// Port-level assertions for the compensation unit, bound to its top level.
module bpc_checker
  import bpc_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               valid_o,
  input logic [31:0]        pressure_q24_8_o,
  input logic               divide_by_zero_o
);

  // Every accepted transaction produces a result after the fixed latency.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##BPC_LATENCY valid_o)
    else $error("accepted transaction produced no result");

  // No result appears without a transaction accepted one latency earlier.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy, BPC_LATENCY))
    else $error("result without a matching transaction");

  // A zero denominator forces the pressure to zero.
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && divide_by_zero_o) |-> (pressure_q24_8_o == 32'd0))
    else $error("pressure not zero on divide by zero");

endmodule

bind baro_temp_pressure_compensation_unit bpc_checker u_bpc_checker (.*);

// ===== test/baro_temp_pressure_compensation_unit_test.sv =====
// Self-checking testbench of the barometric temperature and pressure compensation unit.
module baro_temp_pressure_compensation_unit_test;
  import bpc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Fixed-point constant of the pressure formula and limits of the run.
  localparam longint unsigned ONE_ONE_SHIFTED = 64'h0000_8000_0000_0000;
  localparam int unsigned MAX_WAIT = 11;
  localparam int unsigned DIRECTED_COUNT = 12;
  localparam int unsigned RANDOM_COUNT = 1600;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [19:0] raw_pressure_i;
  logic [19:0] raw_temperature_i;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [63:0] cfg_wdata_i;
  logic        valid_o;
  logic signed [31:0] fine_temperature_o;
  logic signed [31:0] temperature_centi_o;
  logic [31:0] pressure_q24_8_o;
  logic        divide_by_zero_o;

  // One compensated sample as the unit reports it.
  typedef struct packed {
    logic [31:0] tfine;
    logic [31:0] tcent;
    logic [31:0] pres;
    logic        dz;
  } sample_t;

  // One row of the directed table. A row with check_fixed set also carries the
  // result that can be read off the formula directly.
  typedef struct {
    logic [19:0] pres_raw;
    logic [19:0] temp_raw;
    logic        check_fixed;
    sample_t     fixed;
  } directed_row_t;

  // Local copies of the calibration registers.
  logic [47:0] cal_temp;
  logic [63:0] cal_pres_low;
  logic [63:0] cal_pres_high;
  logic [15:0] cal_pres_last;

  sample_t         pending_samples[$];
  directed_row_t   directed_rows[DIRECTED_COUNT];
  int unsigned     mismatch_count;
  longint unsigned cycle_count;

  baro_temp_pressure_compensation_unit uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .raw_pressure_i      (raw_pressure_i),
    .raw_temperature_i   (raw_temperature_i),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .valid_o             (valid_o),
    .fine_temperature_o  (fine_temperature_o),
    .temperature_centi_o (temperature_centi_o),
    .pressure_q24_8_o    (pressure_q24_8_o),
    .divide_by_zero_o    (divide_by_zero_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Signed divides that truncate toward zero. SystemVerilog division of signed
  // operands already truncates, but a divide by minus one of the most negative
  // value must wrap, so it is handled on its own.
  function automatic longint div_trunc(input longint num, input longint den);
    if (den == -1) begin
      return -num;
    end
    return num / den;
  endfunction

  // Computes the compensated sample from the raw readings and the calibration.
  function automatic sample_t compensate(input logic [19:0] pres_raw,
                                         input logic [19:0] temp_raw);
    int     adc_p;
    int     adc_t;
    int     t1;
    int     t2;
    int     t3;
    int     part_a;
    int     delta;
    int     part_b;
    int     tfine;
    int     tcent;
    longint p1;
    longint p2;
    longint p3;
    longint p4;
    longint p5;
    longint p6;
    longint p7;
    longint p8;
    longint p9;
    longint var1;
    longint var2;
    longint pr;
    sample_t res;
    adc_p = int'(pres_raw & RAW_MASK);
    adc_t = int'(temp_raw & RAW_MASK);
    t1 = int'({16'd0, cal_temp[15:0]});
    t2 = int'($signed(cal_temp[31:16]));
    t3 = int'($signed(cal_temp[47:32]));
    p1 = longint'({48'd0, cal_pres_low[15:0]});
    p2 = longint'($signed(cal_pres_low[31:16]));
    p3 = longint'($signed(cal_pres_low[47:32]));
    p4 = longint'($signed(cal_pres_low[63:48]));
    p5 = longint'($signed(cal_pres_high[15:0]));
    p6 = longint'($signed(cal_pres_high[31:16]));
    p7 = longint'($signed(cal_pres_high[47:32]));
    p8 = longint'($signed(cal_pres_high[63:48]));
    p9 = longint'($signed(cal_pres_last));

    // Temperature path in 32 bits; int arithmetic wraps like the hardware.
    part_a = ((adc_t / 8 - t1 * 2) * t2) / 2048;
    delta  = adc_t / 16 - t1;
    part_b = (((delta * delta) / 4096) * t3) / 16384;
    tfine  = part_a + part_b;
    tcent  = (tfine * 5 + 128) / 256;

    // Pressure path in 64 bits.
    var1 = longint'(tfine) - 128000;
    var2 = var1 * var1 * p6;
    var2 = var2 + var1 * p5 * 131072;
    var2 = var2 + p4 * 64'sd34359738368;
    var1 = (var1 * var1 * p3) / 256 + var1 * p2 * 4096;
    var1 = ((longint'(ONE_ONE_SHIFTED) + var1) * p1) / 64'sd8589934592;

    res.tfine = tfine;
    res.tcent = tcent;
    res.pres  = '0;
    res.dz    = 1'b0;
    if (var1 == 0) begin
      res.dz = 1'b1;
    end else begin
      pr   = 1048576 - longint'(adc_p);
      pr   = div_trunc((pr * 64'sd2147483648 - var2) * 3125, var1);
      var1 = (p9 * (pr / 8192) * (pr / 8192)) / 33554432;
      var2 = (p8 * pr) / 524288;
      pr   = (pr + var1 + var2) / 256 + p7 * 16;
      res.pres = pr[31:0];
    end
    return res;
  endfunction

  // Result monitor: every strobe is matched against the oldest expectation.
  always @(posedge clk_i) begin
    sample_t seen;
    sample_t want;
    if (rst_ni && valid_o) begin
      seen = '{fine_temperature_o, temperature_centi_o, pressure_q24_8_o, divide_by_zero_o};
      if (pending_samples.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < 10) begin
          $display("Unexpected result: tfine %0d tcent %0d pres %h dz %b",
                   $signed(seen.tfine), $signed(seen.tcent), seen.pres, seen.dz);
        end
      end else begin
        want = pending_samples.pop_front();
        if (seen !== want) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) begin
            $display("Mismatch: expected tfine %0d tcent %0d pres %h dz %b",
                     $signed(want.tfine), $signed(want.tcent), want.pres, want.dz);
            $display("          actual   tfine %0d tcent %0d pres %h dz %b",
                     $signed(seen.tfine), $signed(seen.tcent), seen.pres, seen.dz);
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Writes one calibration register; only called while nothing is in flight.
  task automatic write_calibration(input logic [1:0] idx, input logic [63:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    case (idx)
      CFG_CALIB_TEMP:      cal_temp      = value[47:0];
      CFG_CALIB_PRES_LOW:  cal_pres_low  = value;
      CFG_CALIB_PRES_HIGH: cal_pres_high = value;
      default:             cal_pres_last = value[15:0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Loads a full calibration set.
  task automatic load_calibration(input logic [47:0] temp_word, input logic [63:0] low_word,
                                  input logic [63:0] high_word, input logic [15:0] last_word);
    write_calibration(CFG_CALIB_TEMP, {16'd0, temp_word});
    write_calibration(CFG_CALIB_PRES_LOW, low_word);
    write_calibration(CFG_CALIB_PRES_HIGH, high_word);
    write_calibration(CFG_CALIB_PRES_LAST, {48'd0, last_word});
  endtask

  // Waits until every expected result has arrived.
  task automatic drain;
    while (pending_samples.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Presents one transaction after an idle gap chosen by the caller and records its expectation.
  // The task is entered right after a rising edge and returns at the accepting edge,
  // so a following call with no gap drives the next transaction back to back. The
  // caller lowers start once the last transaction of a burst is accepted.
  task automatic send_reading(input logic [19:0] pres_raw, input logic [19:0] temp_raw,
                              input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start             <= 1'b1;
    raw_pressure_i    <= pres_raw;
    raw_temperature_i <= temp_raw;
    do begin
      @(posedge clk_i);
    end while (busy);
    pending_samples.push_back(compensate(pres_raw, temp_raw));
  endtask

  // Sends a slice of the directed table, checking fixed rows against their typed result.
  task automatic run_directed(input int unsigned first_row, input int unsigned end_row);
    sample_t want;
    for (int unsigned i = first_row; i < end_row; i++) begin
      if (directed_rows[i].check_fixed) begin
        want = compensate(directed_rows[i].pres_raw, directed_rows[i].temp_raw);
        if (want !== directed_rows[i].fixed) begin
          mismatch_count++;
          $display("Directed row %0d: formula and typed result disagree", i);
        end
      end
      send_reading(directed_rows[i].pres_raw, directed_rows[i].temp_raw, $urandom_range(0, 2));
    end
  endtask

  // Draws a calibration word near the typical sensor values or fully at random.
  function automatic logic [15:0] calib_word(input logic [15:0] typical);
    if ($urandom_range(0, 3) == 0) begin
      return 16'($urandom);
    end
    return typical + 16'($urandom_range(0, 255)) - 16'd128;
  endfunction

  function automatic logic [19:0] random_raw(input logic [19:0] center);
    case ($urandom_range(0, 5))
      0:       return 20'($urandom);
      1:       return 20'h0_0000;
      2:       return 20'hF_FFFF;
      default: return center + 20'($urandom_range(0, 65535)) - 20'd32768;
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned phase;
    mismatch_count    = 0;
    cycle_count       = 0;
    rst_ni            = 1'b0;
    start             = 1'b0;
    raw_pressure_i    = '0;
    raw_temperature_i = '0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CFG_CALIB_TEMP;
    cfg_wdata_i       = '0;
    cal_temp          = '0;
    cal_pres_low      = '0;
    cal_pres_high     = '0;
    cal_pres_last     = '0;

    // With every calibration word at reset value zero, the pressure denominator
    // is zero: the temperature is zero and the divide-by-zero flag is set.
    directed_rows[0] = '{20'h0_0000, 20'h0_0000, 1'b1, '{32'd0, 32'd0, 32'd0, 1'b1}};
    directed_rows[1] = '{20'hF_FFFF, 20'hF_FFFF, 1'b1, '{32'd0, 32'd0, 32'd0, 1'b1}};
    directed_rows[2] = '{20'h8_0000, 20'h7_FFFF, 1'b1, '{32'd0, 32'd0, 32'd0, 1'b1}};
    directed_rows[3] = '{20'h5_5555, 20'hA_AAAA, 1'b1, '{32'd0, 32'd0, 32'd0, 1'b1}};
    // The remaining rows run under typical calibration and use the predictor.
    directed_rows[4]  = '{20'h0_0000, 20'h0_0000, 1'b0, '0};
    directed_rows[5]  = '{20'hF_FFFF, 20'hF_FFFF, 1'b0, '0};
    directed_rows[6]  = '{20'h6_5A00, 20'h7_EE00, 1'b0, '0};
    directed_rows[7]  = '{20'h0_0001, 20'hF_FFFE, 1'b0, '0};
    directed_rows[8]  = '{20'hF_FFFE, 20'h0_0001, 1'b0, '0};
    directed_rows[9]  = '{20'h5_5555, 20'hA_AAAA, 1'b0, '0};
    directed_rows[10] = '{20'hA_AAAA, 20'h5_5555, 1'b0, '0};
    directed_rows[11] = '{20'h8_0000, 20'h8_0000, 1'b0, '0};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset calibration: divide-by-zero rows.
    run_directed(0, 4);
    start <= 1'b0;
    drain();
    repeat (BPC_LATENCY + 4) @(posedge clk_i);

    // Typical datasheet-style calibration, then the rest of the table.
    load_calibration({16'hFE0C, 16'h6A1D, 16'h6C81}, {16'h0BB8, 16'hD0A0, 16'hD67E, 16'h8E4A},
                     {16'h2710, 16'hC3C0, 16'hFFF9, 16'h0050}, 16'h1770);
    run_directed(4, DIRECTED_COUNT);
    start <= 1'b0;
    drain();

    // Extreme calibration sets: all ones, then a mix of most negative and most positive words,
    // each exercised with a few readings.
    load_calibration(48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                     16'hFFFF);
    send_reading(20'h0_0000, 20'hF_FFFF, 0);
    send_reading(20'hF_FFFF, 20'h0_0000, 0);
    start <= 1'b0;
    drain();
    load_calibration({16'h8000, 16'h7FFF, 16'hFFFF}, {16'h8000, 16'h7FFF, 16'h8000, 16'h0001},
                     {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 16'h8000);
    send_reading(20'h0_0000, 20'h0_0000, 0);
    send_reading(20'hF_FFFF, 20'hF_FFFF, 0);
    send_reading(20'h7_FFFF, 20'h8_0000, 0);
    start <= 1'b0;
    drain();

    // Random part in phases with a fresh calibration between phases. Each phase
    // ends with the sender pausing until every result is back.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_COUNT) begin
      if (phase % 5 == 4) begin
        load_calibration(48'($urandom) | (48'($urandom) << 32),
                         {32'($urandom), 32'($urandom)}, {32'($urandom), 32'($urandom)},
                         16'($urandom));
      end else begin
        load_calibration({calib_word(16'hFE0C), calib_word(16'h6A1D), calib_word(16'h6C81)},
                         {calib_word(16'h0BB8), calib_word(16'hD0A0), calib_word(16'hD67E),
                          calib_word(16'h8E4A)},
                         {calib_word(16'h2710), calib_word(16'hC3C0), calib_word(16'hFFF9),
                          calib_word(16'h0050)}, calib_word(16'h1770));
      end
      for (int i = 0; i < 100; i++) begin
        // Every third phase runs back to back to keep the pipeline full.
        send_reading(random_raw(20'h6_5A00), random_raw(20'h7_EE00),
                     (phase % 3 == 0) ? 0 : $urandom_range(0, MAX_WAIT));
      end
      start <= 1'b0;
      drain();
      sent += 100;
      phase++;
    end

    drain();
    repeat (BPC_LATENCY + 8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_samples.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
